// ===== sv/isspr_pkg.sv =====
// Shared types and constants of the inverted serial sensor packet receiver.
// Used by isspr_frame, isspr_skid and the top level; depends on nothing.
package isspr_pkg;

   // Packet layout
   localparam int PACKET_BYTES = 17;
   localparam int SENSOR_COUNT = 8;
   localparam int PAIR_BYTES   = 2 * SENSOR_COUNT;

   // Field and state widths
   localparam int TICK_W  = 20;
   localparam int BIT_W   = 4;
   localparam int POS_W   = 5;
   localparam int PAIR_W  = POS_W - 1;
   localparam int INDEX_W = 3;
   localparam int RAW_W   = 12;
   localparam int CSR_W   = 20;
   localparam int ADDR_W  = 2;

   localparam logic [TICK_W-1:0] TICK_MAX   = '1;
   localparam logic [BIT_W-1:0]  DATA_BITS  = 4'd8;
   localparam logic [BIT_W-1:0]  FIRST_STOP = 4'd8;

   // Register indexes of the configuration port
   localparam logic [ADDR_W-1:0] CSR_BIT_PERIOD   = 2'd0;
   localparam logic [ADDR_W-1:0] CSR_FIRST_SAMPLE = 2'd1;
   localparam logic [ADDR_W-1:0] CSR_START_TMO    = 2'd2;

   // Register reset values
   localparam logic [15:0]       BIT_PERIOD_RST   = 16'd52;
   localparam logic [15:0]       FIRST_SAMPLE_RST = 16'd52;
   localparam logic [TICK_W-1:0] START_TMO_RST    = 20'd1000;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_HUNT,
      PH_BITS
   } phase_type;

   typedef struct packed {
      logic [15:0]       bit_period;
      logic [15:0]       first_sample;
      logic [TICK_W-1:0] start_tmo;
   } cfg_type;

   typedef struct packed {
      logic               last_of_packet;
      logic               start_timed_out;
      logic               framing_error;
      logic [RAW_W-1:0]   reading;
      logic [INDEX_W-1:0] sensor_id;
   } result_type;

endpackage

// ===== sv/isspr_frame.sv =====
// Byte framing, packet position and sensor pair assembly, one tick per cycle while accept is high.
// Depends on isspr_pkg.
module isspr_frame (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic                 line_level,
   input  logic                 begin_packet,
   input  isspr_pkg::cfg_type   cfg,
   output logic                 res_valid,
   output isspr_pkg::result_type res
);

   isspr_pkg::phase_type             phase_ff, phase_in, eff_phase;
   logic [isspr_pkg::TICK_W-1:0]     tick_ff, tick_in, eff_tick, tick_inc, tick_sat, limit;
   logic [isspr_pkg::BIT_W-1:0]      bit_ff, bit_in, eff_bit;
   logic [7:0]                       shift_ff, shift_in, eff_shift;
   logic [isspr_pkg::POS_W-1:0]      pos_ff, pos_in, eff_pos, pos_next;
   logic [7:0]                       held_ff, held_in;
   logic                             pf_ff, pf_in, eff_pf, pf_cur;
   logic                             pt_ff, pt_in, eff_pt, pt_cur;
   logic                             done;
   logic [7:0]                       byte_value;
   logic [isspr_pkg::PAIR_W-1:0]     pair;
   logic                             in_pairs;

   // Begin strobe wipes the packet context before the tick is looked at
   always_comb begin
      eff_phase = begin_packet ? isspr_pkg::PH_HUNT : phase_ff;
      eff_tick  = begin_packet ? '0 : tick_ff;
      eff_bit   = begin_packet ? '0 : bit_ff;
      eff_shift = begin_packet ? '0 : shift_ff;
      eff_pos   = begin_packet ? '0 : pos_ff;
      eff_pf    = begin_packet ? 1'b0 : pf_ff;
      eff_pt    = begin_packet ? 1'b0 : pt_ff;
      tick_inc  = eff_tick + 1'b1;
      tick_sat  = (eff_tick == isspr_pkg::TICK_MAX) ? eff_tick : tick_inc;
      limit     = (eff_bit == '0) ? {4'd0, cfg.first_sample} : {4'd0, cfg.bit_period};
      pos_next  = eff_pos + 1'b1;
      pair      = eff_pos[isspr_pkg::POS_W-1:1];
      in_pairs  = {1'b0, eff_pos} < 6'(isspr_pkg::PAIR_BYTES);
   end

   // Next phase
   always_comb begin
      phase_in = eff_phase;
      case (eff_phase)
         isspr_pkg::PH_HUNT: begin
            if (line_level) begin
               phase_in = isspr_pkg::PH_BITS;
            end
         end
         isspr_pkg::PH_BITS: ;
         default: phase_in = isspr_pkg::PH_IDLE;
      endcase
      if (done) begin
         phase_in = ({1'b0, pos_next} >= 6'(isspr_pkg::PACKET_BYTES)) ?
                    isspr_pkg::PH_IDLE : isspr_pkg::PH_HUNT;
      end
   end

   // Tick counting, bit sampling and byte completion
   always_comb begin
      tick_in    = eff_tick;
      bit_in     = eff_bit;
      shift_in   = eff_shift;
      pf_cur     = eff_pf;
      pt_cur     = eff_pt;
      done       = 1'b0;
      byte_value = eff_shift;
      case (eff_phase)
         isspr_pkg::PH_HUNT: begin
            if (line_level) begin
               tick_in  = '0;
               bit_in   = '0;
               shift_in = '0;
            end else if (tick_inc >= cfg.start_tmo) begin
               pt_cur     = 1'b1;
               done       = 1'b1;
               byte_value = '0;
            end else begin
               tick_in = tick_inc;
            end
         end
         isspr_pkg::PH_BITS: begin
            if (tick_sat < limit) begin
               tick_in = tick_sat;
            end else begin
               tick_in = '0;
               if (eff_bit < isspr_pkg::DATA_BITS) begin
                  // low line is a one
                  shift_in[eff_bit[2:0]] = eff_shift[eff_bit[2:0]] | ~line_level;
                  bit_in = eff_bit + 1'b1;
               end else begin
                  pf_cur = eff_pf | line_level;
                  if (eff_bit == isspr_pkg::FIRST_STOP) begin
                     bit_in = eff_bit + 1'b1;
                  end else begin
                     done = 1'b1;
                  end
               end
            end
         end
         default: ;
      endcase
   end

   // Pair assembly and result
   always_comb begin
      held_in   = held_ff;
      pos_in    = eff_pos;
      pf_in     = pf_cur;
      pt_in     = pt_cur;
      res_valid = 1'b0;
      res.sensor_id       = pair[isspr_pkg::INDEX_W-1:0];
      res.reading         = {byte_value[3:0], held_ff};
      res.framing_error   = pf_cur;
      res.start_timed_out = pt_cur;
      res.last_of_packet  = (pair == isspr_pkg::PAIR_W'(isspr_pkg::SENSOR_COUNT - 1)) ||
                            (({1'b0, eff_pos} + 6'd2) >= 6'(isspr_pkg::PACKET_BYTES));
      if (done) begin
         pos_in = pos_next;
         if (in_pairs && !eff_pos[0]) begin
            held_in = byte_value;
         end else begin
            pf_in     = 1'b0;
            pt_in     = 1'b0;
            res_valid = accept && in_pairs;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= isspr_pkg::PH_IDLE;
         tick_ff  <= '0;
         bit_ff   <= '0;
         shift_ff <= '0;
         pos_ff   <= '0;
         pf_ff    <= 1'b0;
         pt_ff    <= 1'b0;
      end else if (accept) begin
         phase_ff <= phase_in;
         tick_ff  <= done ? '0 : tick_in;
         bit_ff   <= done ? '0 : bit_in;
         shift_ff <= done ? '0 : shift_in;
         pos_ff   <= pos_in;
         pf_ff    <= pf_in;
         pt_ff    <= pt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         held_ff <= held_in;
      end
   end

endmodule

// ===== sv/isspr_skid.sv =====
// Result register with one skid entry behind it.
// Depends on isspr_pkg.
module isspr_skid (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  isspr_pkg::result_type in_data,
   output logic                  in_ready,
   output logic                  out_valid,
   output isspr_pkg::result_type out_data,
   input  logic                  out_ready
);

   logic                  main_valid_ff, main_valid_in;
   logic                  skid_valid_ff, skid_valid_in;
   isspr_pkg::result_type main_ff, main_in, skid_ff, skid_in;

   always_comb begin
      main_valid_in = main_valid_ff;
      main_in       = main_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (!main_valid_ff || out_ready) begin
         // advance: skid entry first, it is older
         main_valid_in = skid_valid_ff | in_valid;
         main_in       = skid_valid_ff ? skid_ff : in_data;
         skid_valid_in = 1'b0;
      end else if (in_valid) begin
         skid_valid_in = 1'b1;
         skid_in       = in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign in_ready  = !skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;

endmodule

// ===== sv/inverted_serial_sensor_packet_rx.sv =====
// Top level of the inverted serial sensor packet receiver.
// Depends on isspr_pkg, isspr_frame and isspr_skid.
//
//   channel | direction | words                                  | handshake
//   req     | in        | one line tick: level + begin strobe    | tvalid/tready
//   rsp     | out       | one sensor value with flags            | tvalid/tready
//   csr     | in        | register write, index + data           | csr_we only
//
// Cycles: one tick word is taken every cycle while req_tready is high; a sensor
// value enters the result or skid register on the tick closing its high byte.
// Stalls: a result register and one skid entry sit on rsp; req_tready drops only
// while both hold a value, and rises again as soon as rsp takes one.
// Reset: synchronous, active high; it returns the receiver to idle and loads the
// register defaults (bit period 52, first sample 52, start timeout 1000).
module inverted_serial_sensor_packet_rx (
   input  logic        clock,
   input  logic        reset,
   // tick channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [0] line_level, [7:1] zero
   input  logic        req_tuser,   // [0] begin_packet
   // sensor value channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [2:0] sensor_id, [14:3] reading, [15] zero
   output logic [1:0]  rsp_tuser,   // [0] framing_error, [1] start_timed_out
   output logic        rsp_tlast,   // last_of_packet
   // configuration writes
   input  logic        csr_we,
   input  logic [isspr_pkg::ADDR_W-1:0] csr_addr,
   input  logic [isspr_pkg::CSR_W-1:0]  csr_wdata
);

   isspr_pkg::cfg_type    cfg_ff, cfg_in;
   isspr_pkg::result_type res, rsp_word;
   logic                  res_valid;
   logic                  req_accept;

   // Register file: drop writes to unknown indexes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_addr)
            isspr_pkg::CSR_BIT_PERIOD:   cfg_in.bit_period   = csr_wdata[15:0];
            isspr_pkg::CSR_FIRST_SAMPLE: cfg_in.first_sample = csr_wdata[15:0];
            isspr_pkg::CSR_START_TMO:    cfg_in.start_tmo    = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bit_period   <= isspr_pkg::BIT_PERIOD_RST;
         cfg_ff.first_sample <= isspr_pkg::FIRST_SAMPLE_RST;
         cfg_ff.start_tmo    <= isspr_pkg::START_TMO_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_accept = req_tvalid && req_tready;

   // Byte framing and pair assembly: state advances on every accepted tick
   isspr_frame u_frame (
      .clock        (clock),
      .reset        (reset),
      .accept       (req_accept),
      .line_level   (req_tdata[0]),
      .begin_packet (req_tuser),
      .cfg          (cfg_ff),
      .res_valid    (res_valid),
      .res          (res)
   );

   // Hold results until rsp takes them
   isspr_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (res_valid),
      .in_data   (res),
      .in_ready  (req_tready),
      .out_valid (rsp_tvalid),
      .out_data  (rsp_word),
      .out_ready (rsp_tready)
   );

   assign rsp_tdata = {1'b0, rsp_word.reading, rsp_word.sensor_id};
   assign rsp_tuser = {rsp_word.start_timed_out, rsp_word.framing_error};
   assign rsp_tlast = rsp_word.last_of_packet;

   // A result only comes from a tick that was taken
   a_res_from_tick: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> req_accept)
      else $error("result produced without an accepted tick");

   // Backpressure on req only while the result register is full
   a_stall_needs_rsp: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("req stalled with empty result register");

   // The packet holds every pair, so the last value is the top sensor
   a_last_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |->
         (rsp_tdata[2:0] == isspr_pkg::INDEX_W'(isspr_pkg::SENSOR_COUNT - 1)))
      else $error("last_of_packet on a sensor other than the final one");

endmodule

// ===== tb/sv/inverted_serial_sensor_packet_rx_tb.sv =====
// Self-checking testbench for inverted_serial_sensor_packet_rx: line ticks in,
// sensor values out, checked against a cycle-free predictor of the receiver.
// Depends on isspr_pkg and the receiver RTL only.
module inverted_serial_sensor_packet_rx_tb;
   timeunit 1ns;
   timeprecision 1ps;

   // One row of the directed tick table; typed rows carry their own answer
   typedef struct {
      logic                  line;
      logic                  strobe;
      bit                    typed;
      bit                    gives;
      isspr_pkg::result_type want;
   } tick_row_type;

   localparam isspr_pkg::result_type NO_VALUE = '0;

   logic                         clock;
   logic                         reset;
   logic                         req_tvalid;
   logic                         req_tready;
   logic [7:0]                   req_tdata;   // [0] line_level, [7:1] zero
   logic                         req_tuser;   // [0] begin_packet
   logic                         rsp_tvalid;
   logic                         rsp_tready = 1'b0;
   logic [15:0]                  rsp_tdata;   // [2:0] sensor_id, [14:3] reading, [15] zero
   logic [1:0]                   rsp_tuser;   // [0] framing_error, [1] start_timed_out
   logic                         rsp_tlast;   // last_of_packet
   logic                         csr_we;
   logic [isspr_pkg::ADDR_W-1:0] csr_addr;
   logic [isspr_pkg::CSR_W-1:0]  csr_wdata;

   // Idle rates of the two sides, in percent of cycles
   int send_gap_pct   = 15;
   int recv_stall_pct = 64;

   // Predictor copy of the receiver registers and state
   logic [15:0]                  cfg_bit_period = isspr_pkg::BIT_PERIOD_RST;
   logic [15:0]                  cfg_first      = isspr_pkg::FIRST_SAMPLE_RST;
   logic [isspr_pkg::TICK_W-1:0] cfg_timeout    = isspr_pkg::START_TMO_RST;
   isspr_pkg::phase_type         m_phase = isspr_pkg::PH_IDLE;
   logic [isspr_pkg::TICK_W-1:0] m_ticks = '0;
   logic [isspr_pkg::BIT_W-1:0]  m_bit   = '0;
   logic [7:0]                   m_shift = '0;
   logic [isspr_pkg::POS_W-1:0]  m_pos   = '0;
   logic [7:0]                   m_low   = '0;
   logic                         m_fe    = 1'b0;
   logic                         m_to    = 1'b0;

   isspr_pkg::result_type expected_values[$];
   tick_row_type          tick_rows[$];

   bit begin_due        = 1'b0;
   int ticks_sent       = 0;
   int values_predicted = 0;
   int values_checked   = 0;
   int settings_used    = 0;
   int error_count      = 0;

   inverted_serial_sensor_packet_rx dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop well past the slowest legal run
   initial begin
      #5_000_000;
      $display("inverted_serial_sensor_packet_rx_tb: errors");
      $finish;
   end

   // Stall the sensor value channel at the current rate
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   task automatic report_mismatch(input string what);
      error_count++;
      $display("%0t ns: %s", $time, what);
   endtask

   // Close the current byte: hold a low byte, or emit a sensor value on a high
   // byte; bytes past the sensor pairs just drop their flags.
   task automatic close_byte(input logic [7:0] value);
      isspr_pkg::result_type v;
      logic [isspr_pkg::POS_W-1:0] pos;
      pos = m_pos;
      if (pos < isspr_pkg::PAIR_BYTES) begin
         if (!pos[0]) begin
            m_low = value;
         end else begin
            v.sensor_id       = pos[3:1];
            v.reading         = {value[3:0], m_low};
            v.framing_error   = m_fe;
            v.start_timed_out = m_to;
            v.last_of_packet  = (pos[4:1] == isspr_pkg::SENSOR_COUNT - 1) ||
                                (pos + 2 >= isspr_pkg::PACKET_BYTES);
            expected_values.push_back(v);
            values_predicted++;
            m_fe = 1'b0;
            m_to = 1'b0;
         end
      end else begin
         m_fe = 1'b0;
         m_to = 1'b0;
      end
      m_pos   = pos + 1'b1;
      m_ticks = '0;
      m_bit   = '0;
      m_shift = '0;
      m_phase = (m_pos >= isspr_pkg::PACKET_BYTES) ? isspr_pkg::PH_IDLE : isspr_pkg::PH_HUNT;
   endtask

   // Advance the predictor by one accepted tick
   task automatic predict_tick(input logic line, input logic strobe);
      logic [15:0] limit;
      if (strobe) begin
         m_phase = isspr_pkg::PH_HUNT;
         m_pos   = '0;
         m_ticks = '0;
         m_bit   = '0;
         m_shift = '0;
         m_fe    = 1'b0;
         m_to    = 1'b0;
      end
      case (m_phase)
         isspr_pkg::PH_HUNT: begin
            if (line) begin
               m_phase = isspr_pkg::PH_BITS;
               m_ticks = '0;
               m_bit   = '0;
               m_shift = '0;
            end else begin
               m_ticks = m_ticks + 1'b1;
               if (m_ticks >= cfg_timeout) begin
                  m_to = 1'b1;
                  close_byte(8'h00);
               end
            end
         end
         isspr_pkg::PH_BITS: begin
            limit = (m_bit == 0) ? cfg_first : cfg_bit_period;
            if (m_ticks != isspr_pkg::TICK_MAX) m_ticks = m_ticks + 1'b1;
            if (m_ticks >= limit) begin
               m_ticks = '0;
               if (m_bit < isspr_pkg::DATA_BITS) begin
                  // inverted line: low means a one bit
                  if (!line) m_shift[m_bit[2:0]] = 1'b1;
                  m_bit = m_bit + 1'b1;
               end else begin
                  if (line) m_fe = 1'b1;
                  if (m_bit == isspr_pkg::FIRST_STOP) m_bit = m_bit + 1'b1;
                  else close_byte(m_shift);
               end
            end
         end
         default: m_phase = isspr_pkg::PH_IDLE;
      endcase
   endtask

   // Offer one tick word, optionally after a gap, and hold it until taken
   task automatic send_tick(input logic line);
      logic rdy;
      if ($urandom_range(0, 99) < send_gap_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < send_gap_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'd0, line};
      req_tuser  <= begin_due;
      do begin
         @(negedge clock);
         rdy = req_tready;
         @(posedge clock);
      end while (!rdy);
      // ignored idle ticks do not count as stimulus
      if (begin_due || m_phase != isspr_pkg::PH_IDLE) ticks_sent++;
      predict_tick(line, begin_due);
      begin_due = 1'b0;
   endtask

   // Drop valid and hold off until every predicted value is out
   task automatic wait_drained(input int settle);
      req_tvalid <= 1'b0;
      while (expected_values.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic set_config(input logic [15:0] bp, input logic [15:0] fs,
                             input logic [isspr_pkg::TICK_W-1:0] tmo);
      wait_drained(4);
      csr_we    <= 1'b1;
      csr_addr  <= isspr_pkg::CSR_BIT_PERIOD;
      csr_wdata <= {4'd0, bp};
      @(posedge clock);
      csr_addr  <= isspr_pkg::CSR_FIRST_SAMPLE;
      csr_wdata <= {4'd0, fs};
      @(posedge clock);
      csr_addr  <= isspr_pkg::CSR_START_TMO;
      csr_wdata <= tmo;
      @(posedge clock);
      csr_we <= 1'b0;
      cfg_bit_period = bp;
      cfg_first      = fs;
      cfg_timeout    = tmo;
      settings_used++;
      @(posedge clock);
   endtask

   // Drive one byte: hunt lows, start, eight data and two stop bits (a high stop bit is a
   // framing error), each level landing on its sample tick with noise in between; give_up only times out the hunt.
   task automatic send_byte(input logic [7:0] value, input logic stop_hi0,
                            input logic stop_hi1, input bit give_up);
      int first_eff, period_eff, tmo_eff, lows, limit, i, k;
      logic level;
      first_eff  = (cfg_first == 0) ? 1 : int'(cfg_first);
      period_eff = (cfg_bit_period == 0) ? 1 : int'(cfg_bit_period);
      tmo_eff    = (cfg_timeout == 0) ? 1 : int'(cfg_timeout);
      lows = give_up ? tmo_eff : $urandom_range(0, (tmo_eff - 1 < 3) ? tmo_eff - 1 : 3);
      for (i = 0; i < lows; i++) send_tick(1'b0);
      if (give_up) return;
      send_tick(1'b1);
      for (i = 0; i < 10; i++) begin
         limit = (i == 0) ? first_eff : period_eff;
         for (k = 1; k < limit; k++) send_tick(1'($urandom_range(0, 1)));
         if (i < 8) level = ~value[i];
         else level = (i == 8) ? stop_hi0 : stop_hi1;
         send_tick(level);
      end
   endtask

   task automatic send_packet(input int nbytes, input int tmo_pct);
      int b;
      begin_due = 1'b1;
      for (b = 0; b < nbytes; b++) begin
         // now and then stall mid-packet until all values are out
         if (b == 9 && $urandom_range(0, 3) == 0) wait_drained(0);
         send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0,
                   $urandom_range(0, 9) == 0, $urandom_range(0, 99) < tmo_pct);
      end
      // a few ticks with the receiver idle again
      if (nbytes == isspr_pkg::PACKET_BYTES)
         repeat ($urandom_range(0, 3)) send_tick(1'($urandom_range(0, 1)));
   endtask

   task automatic send_noise(input int n);
      repeat (n) begin
         begin_due = ($urandom_range(0, 19) == 0);
         send_tick(1'($urandom_range(0, 1)));
      end
   endtask

   // Check each taken sensor value against the oldest prediction; sample at
   // the falling edge, the word moves at the next rising edge.
   always @(negedge clock) begin : watch_values
      isspr_pkg::result_type got;
      isspr_pkg::result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.sensor_id       = rsp_tdata[2:0];
         got.reading         = rsp_tdata[14:3];
         got.framing_error   = rsp_tuser[0];
         got.start_timed_out = rsp_tuser[1];
         got.last_of_packet  = rsp_tlast;
         if (expected_values.size() == 0) begin
            report_mismatch($sformatf("unexpected value idx %0d raw %03h",
                                      got.sensor_id, got.reading));
         end else begin
            want = expected_values.pop_front();
            values_checked++;
            if (got.sensor_id !== want.sensor_id)
               report_mismatch($sformatf("sensor_id %0d, want %0d",
                                         got.sensor_id, want.sensor_id));
            if (got.reading !== want.reading)
               report_mismatch($sformatf("reading %03h, want %03h",
                                         got.reading, want.reading));
            if (got.framing_error !== want.framing_error)
               report_mismatch($sformatf("framing_error %b, want %b",
                                         got.framing_error, want.framing_error));
            if (got.start_timed_out !== want.start_timed_out)
               report_mismatch($sformatf("start_timed_out %b, want %b",
                                         got.start_timed_out, want.start_timed_out));
            if (got.last_of_packet !== want.last_of_packet)
               report_mismatch($sformatf("last_of_packet %b, want %b",
                                         got.last_of_packet, want.last_of_packet));
         end
      end
   end

   initial begin : run_test
      tick_row_type row;
      int           n0, mode, stop_at;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= 1'b0;
      csr_we     <= 1'b0;
      csr_addr   <= isspr_pkg::CSR_BIT_PERIOD;
      csr_wdata  <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Two bytes at the reset timing: checks the register defaults
      send_packet(2, 0);

      // Directed table at the fastest timing, every sample on one tick.
      // Timeout of one: each low hunt tick gives up a byte as zero.
      set_config(16'd1, 16'd1, 20'd1);
      tick_rows.push_back('{1'b0, 1'b1, 1'b1, 1'b0, NO_VALUE});
      tick_rows.push_back('{1'b0, 1'b0, 1'b1, 1'b1,
                            isspr_pkg::result_type'{1'b0, 1'b1, 1'b0, 12'h000, 3'd0}});
      // start bit, eight low data ticks (0xFF), two clean stop bits
      tick_rows.push_back('{1'b1, 1'b0, 1'b0, 1'b0, NO_VALUE});
      repeat (10) tick_rows.push_back('{1'b0, 1'b0, 1'b0, 1'b0, NO_VALUE});
      // high byte 0xFF, upper nibble masked, first stop bit high
      tick_rows.push_back('{1'b1, 1'b0, 1'b0, 1'b0, NO_VALUE});
      repeat (8) tick_rows.push_back('{1'b0, 1'b0, 1'b0, 1'b0, NO_VALUE});
      tick_rows.push_back('{1'b1, 1'b0, 1'b0, 1'b0, NO_VALUE});
      tick_rows.push_back('{1'b0, 1'b0, 1'b1, 1'b1,
                            isspr_pkg::result_type'{1'b0, 1'b0, 1'b1, 12'hFFF, 3'd1}});
      // restart mid-packet with the start bit on the strobe tick
      tick_rows.push_back('{1'b1, 1'b1, 1'b1, 1'b0, NO_VALUE});
      foreach (tick_rows[i]) begin
         row       = tick_rows[i];
         n0        = values_predicted;
         begin_due = row.strobe;
         send_tick(row.line);
         if (row.typed) begin
            if (values_predicted != n0) expected_values.pop_back();
            if (row.gives) expected_values.push_back(row.want);
         end
      end

      // Random part in three idling modes
      for (mode = 0; mode < 3; mode++) begin
         case (mode)
            0: begin send_gap_pct = 15; recv_stall_pct = 64; end
            1: begin send_gap_pct = 64; recv_stall_pct = 15; end
            default: begin send_gap_pct = 0; recv_stall_pct = 0; end
         endcase
         stop_at = ticks_sent + 200;
         if (mode == 0) begin
            // zero registers behave as one
            set_config(16'd0, 16'd0, 20'd0);
            send_packet(isspr_pkg::PACKET_BYTES, 12);
         end
         if (mode == 1) begin
            // maximum registers: hunt and start, no sample is ever reached
            set_config(16'hFFFF, 16'hFFFF, 20'hFFFFF);
            begin_due = 1'b1;
            repeat (40) send_tick(1'b0);
            send_tick(1'b1);
            repeat (60) send_tick(1'($urandom_range(0, 1)));
         end
         do begin
            set_config($urandom_range(0, 1) ? 16'd1 : 16'($urandom_range(2, 3)),
                       16'($urandom_range(1, 4)), 20'($urandom_range(1, 24)));
            case ($urandom_range(0, 7))
               0: send_packet($urandom_range(1, isspr_pkg::PACKET_BYTES - 1), 12);
               1: send_noise($urandom_range(5, 40));
               default: send_packet(isspr_pkg::PACKET_BYTES, 12);
            endcase
         end while (ticks_sent < stop_at);
      end

      // Drain, then allow the pipeline to settle
      wait_drained(8);
      $display("covered %0d line ticks and %0d sensor values", ticks_sent, values_checked);
      $display("over %0d register settings incl. defaults, zero, min and max", settings_used);
      if (error_count == 0) begin
         $display("inverted_serial_sensor_packet_rx_tb: clean");
      end else begin
         $display("inverted_serial_sensor_packet_rx_tb: errors");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
sv/isspr_pkg.sv
sv/isspr_frame.sv
sv/isspr_skid.sv
sv/inverted_serial_sensor_packet_rx.sv
tb/sv/inverted_serial_sensor_packet_rx_tb.sv
